### hdl/tgi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_pkg
// shared constants, types and helpers of the trilinear grid interpolator
// ----------------------------------------------------------------------------
package tgi_pkg;

    localparam int NUM_AXES        = 3;
    localparam int VAL_W           = 32;
    localparam int STEP_W          = 31;
    localparam int ADDR_W          = 12;
    localparam int STORE_DEPTH     = 4096;
    localparam int IDX_W           = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 32;
    localparam int AXIS_POINTS_DEF = 16;

    localparam logic [STEP_W-1:0] STEP_RESET = 31'd65536;

    localparam logic [2:0] REG_AXIS1_ORIGIN = 3'd0;
    localparam logic [2:0] REG_AXIS2_ORIGIN = 3'd1;
    localparam logic [2:0] REG_AXIS3_ORIGIN = 3'd2;
    localparam logic [2:0] REG_AXIS1_STEP   = 3'd3;
    localparam logic [2:0] REG_AXIS2_STEP   = 3'd4;
    localparam logic [2:0] REG_AXIS3_STEP   = 3'd5;

    localparam logic ACTION_QUERY = 1'b0;
    localparam logic ACTION_LOAD  = 1'b1;

    typedef struct packed {
        logic [NUM_AXES-1:0][VAL_W-1:0]  origin;
        logic [NUM_AXES-1:0][STEP_W-1:0] step;
    } tgi_cfg_t;

    typedef struct packed {
        logic                            is_load;
        logic                            oor;
        logic [ADDR_W-1:0]               addr;
        logic [VAL_W-1:0]                value;
        logic [NUM_AXES-1:0][STEP_W-1:0] rem;
    } tgi_work_t;

    // a zero step acts as a step of one
    function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] s);
        return (s == '0) ? STEP_W'(1) : s;
    endfunction

endpackage

### hdl/tgi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi item and result channels
// valid/ready channels carrying query/load items and interpolation results
// ----------------------------------------------------------------------------
interface tgi_item_if;
    import tgi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [ADDR_W-1:0]        entry_addr;
    logic signed [VAL_W-1:0]  entry_value;
    logic signed [VAL_W-1:0]  coord1;
    logic signed [VAL_W-1:0]  coord2;
    logic signed [VAL_W-1:0]  coord3;

    modport source (output valid, action, entry_addr, entry_value, coord1, coord2, coord3,
                    input ready);
    modport sink   (input valid, action, entry_addr, entry_value, coord1, coord2, coord3,
                    output ready);
endinterface

interface tgi_result_if;
    import tgi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  interp_value;
    logic                     out_of_range;

    modport source (output valid, interp_value, out_of_range, input ready);
    modport sink   (input valid, interp_value, out_of_range, output ready);
endinterface

### hdl/tgi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_front
// accepts items, range-checks coordinates and finds cell index and remainder
// ----------------------------------------------------------------------------
module tgi_front #(
    parameter int AXIS1_POINTS = tgi_pkg::AXIS_POINTS_DEF,
    parameter int AXIS2_POINTS = tgi_pkg::AXIS_POINTS_DEF,
    parameter int AXIS3_POINTS = tgi_pkg::AXIS_POINTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tgi_pkg::tgi_cfg_t cfg,
    tgi_item_if.sink          item,
    output logic              push_valid,
    input  logic              push_ready,
    output tgi_pkg::tgi_work_t push_data
);
    import tgi_pkg::*;

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_CHECK = 2'd1;
    localparam logic [1:0] F_DIV   = 2'd2;
    localparam logic [1:0] F_PUSH  = 2'd3;

    localparam int SPAN_W = STEP_W + IDX_W;
    localparam int DSR_W  = STEP_W + IDX_W - 1;
    localparam int CNT_W  = $clog2(IDX_W);
    localparam int STRIDE1 = AXIS2_POINTS * AXIS3_POINTS;
    localparam int STRIDE2 = AXIS3_POINTS;

    localparam logic [IDX_W-1:0] LAST_IDX [NUM_AXES] = '{
        IDX_W'(AXIS1_POINTS - 1), IDX_W'(AXIS2_POINTS - 1), IDX_W'(AXIS3_POINTS - 1)};
    localparam logic [IDX_W-1:0] PENULT_IDX [NUM_AXES] = '{
        IDX_W'(AXIS1_POINTS - 2), IDX_W'(AXIS2_POINTS - 2), IDX_W'(AXIS3_POINTS - 2)};

    logic [1:0]            state_reg;
    logic                  is_load_reg;
    logic                  oor_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [VAL_W-1:0]      value_reg;
    logic [VAL_W:0]        d_reg   [NUM_AXES];
    logic [VAL_W-1:0]      rem_reg [NUM_AXES];
    logic [DSR_W-1:0]      dsr_reg [NUM_AXES];
    logic [IDX_W-1:0]      quo_reg [NUM_AXES];
    logic [CNT_W-1:0]      cnt_reg;

    logic [VAL_W-1:0]      coord_in [NUM_AXES];
    logic [NUM_AXES-1:0]   in_span;
    logic [IDX_W-1:0]      idx_fin [NUM_AXES];
    logic [STEP_W-1:0]     rem_fin [NUM_AXES];
    logic [DSR_W-1:0]      rem_ext [NUM_AXES];
    logic [NUM_AXES-1:0]   trial_ge;

    assign coord_in[0] = item.coord1;
    assign coord_in[1] = item.coord2;
    assign coord_in[2] = item.coord3;

    assign item.ready = (state_reg == F_IDLE);

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            in_span[a]  = !d_reg[a][VAL_W] &&
                          (SPAN_W'(d_reg[a][VAL_W-1:0]) <=
                           SPAN_W'(LAST_IDX[a]) * SPAN_W'(eff_step(cfg.step[a])));
            rem_ext[a]  = DSR_W'(rem_reg[a]);
            trial_ge[a] = (rem_ext[a] >= dsr_reg[a]);
            // an offset right at the axis end falls into the last cell
            if (quo_reg[a] == LAST_IDX[a])
            begin
                idx_fin[a] = PENULT_IDX[a];
                rem_fin[a] = eff_step(cfg.step[a]);
            end
            else
            begin
                idx_fin[a] = quo_reg[a];
                rem_fin[a] = rem_reg[a][STEP_W-1:0];
            end
        end
    end

    always_comb
    begin
        push_valid        = (state_reg == F_PUSH);
        push_data.is_load = is_load_reg;
        push_data.oor     = oor_reg;
        push_data.value   = value_reg;
        if (is_load_reg)
            push_data.addr = addr_reg;
        else
            push_data.addr = ADDR_W'(32'(idx_fin[0]) * 32'(STRIDE1)
                                   + 32'(idx_fin[1]) * 32'(STRIDE2)
                                   + 32'(idx_fin[2]));
        for (int a = 0; a < NUM_AXES; a++)
            push_data.rem[a] = rem_fin[a];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (item.valid)
                        state_reg <= F_CHECK;
                end
                F_CHECK:
                begin
                    cnt_reg <= '0;
                    if (is_load_reg || !(&in_span))
                        state_reg <= F_PUSH;
                    else
                        state_reg <= F_DIV;
                end
                F_DIV:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(IDX_W - 1))
                        state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (push_ready)
                        state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && item.valid)
        begin
            is_load_reg <= (item.action == ACTION_LOAD);
            addr_reg    <= item.entry_addr;
            value_reg   <= item.entry_value;
            for (int a = 0; a < NUM_AXES; a++)
                d_reg[a] <= {coord_in[a][VAL_W-1], coord_in[a]}
                          - {cfg.origin[a][VAL_W-1], cfg.origin[a]};
        end
        if (state_reg == F_CHECK)
        begin
            oor_reg <= !(&in_span);
            for (int a = 0; a < NUM_AXES; a++)
            begin
                rem_reg[a] <= d_reg[a][VAL_W-1:0];
                dsr_reg[a] <= {eff_step(cfg.step[a]), {(IDX_W-1){1'b0}}};
                quo_reg[a] <= '0;
            end
        end
        if (state_reg == F_DIV)
        begin
            // restoring division, one quotient bit per cycle on each axis
            for (int a = 0; a < NUM_AXES; a++)
            begin
                if (trial_ge[a])
                    rem_reg[a] <= VAL_W'(rem_ext[a] - dsr_reg[a]);
                quo_reg[a] <= {quo_reg[a][IDX_W-2:0], trial_ge[a]};
                dsr_reg[a] <= dsr_reg[a] >> 1;
            end
        end
    end

endmodule

### hdl/tgi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_queue
// short fifo of classified work between front and back
// ----------------------------------------------------------------------------
module tgi_queue #(
    parameter int DEPTH = tgi_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  tgi_pkg::tgi_work_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output tgi_pkg::tgi_work_t pop_data
);
    import tgi_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tgi_work_t         entries [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != (PTR_W + 1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (PTR_W + 1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_data;
    end

endmodule

### hdl/tgi_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_lerp
// one linear interpolation v0 + round((v1 - v0) * r / s), bit-serial divide
// ----------------------------------------------------------------------------
module tgi_lerp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [tgi_pkg::VAL_W-1:0] v0,
    input  logic signed [tgi_pkg::VAL_W-1:0] v1,
    input  logic [tgi_pkg::STEP_W-1:0]       r,
    input  logic [tgi_pkg::STEP_W-1:0]       s,
    output logic                             done,
    output logic signed [tgi_pkg::VAL_W-1:0] result
);
    import tgi_pkg::*;

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_MUL  = 3'd1;
    localparam logic [2:0] L_NORM = 3'd2;
    localparam logic [2:0] L_DIV  = 3'd3;
    localparam logic [2:0] L_FIN  = 3'd4;

    localparam int PROD_W = 2 * VAL_W + 1;
    localparam int NUM_W  = PROD_W + 1;
    localparam int QW     = VAL_W + 2;
    localparam int CNT_W  = $clog2(VAL_W);

    logic [2:0]               state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [VAL_W:0]    diff_reg;
    logic signed [VAL_W-1:0]  v0_reg;
    logic [STEP_W-1:0]        r_reg;
    logic [STEP_W-1:0]        s_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic [VAL_W-1:0]         rem_reg;
    logic [VAL_W-1:0]         num_reg;
    logic [VAL_W-1:0]         quo_reg;
    logic                     done_reg;
    logic signed [VAL_W-1:0]  result_reg;

    logic signed [PROD_W-1:0] prod;
    logic signed [NUM_W-1:0]  numer;
    logic [NUM_W-1:0]         mag;
    logic [VAL_W-1:0]         den;
    logic [VAL_W:0]           trial;
    logic                     trial_ge;
    logic [QW-1:0]            qmag;
    logic [QW-1:0]            qsig;
    logic [QW:0]              sum;

    assign prod  = diff_reg * $signed({1'b0, r_reg});
    // 2p + s over 2s gives the quotient rounded half up after a floor
    assign numer = $signed({prod_reg, 1'b0}) + $signed({{(NUM_W - STEP_W){1'b0}}, s_reg});
    assign mag   = numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
    assign den   = {s_reg, 1'b0};
    assign trial = {rem_reg, num_reg[VAL_W-1]};
    assign trial_ge = (trial >= {1'b0, den});
    assign qmag  = {2'b00, quo_reg} + QW'(neg_reg && (rem_reg != '0));
    assign qsig  = neg_reg ? QW'(-qmag) : qmag;
    assign sum   = {qsig[QW-1], qsig} + {{(QW + 1 - VAL_W){v0_reg[VAL_W-1]}}, v0_reg};

    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == L_FIN);
            unique case (state_reg)
                L_IDLE: if (start) state_reg <= L_MUL;
                L_MUL:  state_reg <= L_NORM;
                L_NORM:
                begin
                    cnt_reg   <= '0;
                    state_reg <= L_DIV;
                end
                L_DIV:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(VAL_W - 1))
                        state_reg <= L_FIN;
                end
                L_FIN:
                begin
                    state_reg <= L_IDLE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == L_IDLE && start)
        begin
            diff_reg <= {v1[VAL_W-1], v1} - {v0[VAL_W-1], v0};
            v0_reg   <= v0;
            r_reg    <= r;
            s_reg    <= s;
        end
        if (state_reg == L_MUL)
            prod_reg <= prod;
        if (state_reg == L_NORM)
        begin
            neg_reg <= numer[NUM_W-1];
            rem_reg <= mag[2*VAL_W-1:VAL_W];
            num_reg <= mag[VAL_W-1:0];
            quo_reg <= '0;
        end
        if (state_reg == L_DIV)
        begin
            rem_reg <= trial_ge ? VAL_W'(trial - {1'b0, den}) : VAL_W'(trial);
            num_reg <= {num_reg[VAL_W-2:0], 1'b0};
            quo_reg <= {quo_reg[VAL_W-2:0], trial_ge};
        end
        if (state_reg == L_FIN)
        begin
            if (sum[QW:VAL_W-1] == '0 || sum[QW:VAL_W-1] == '1)
                result_reg <= sum[VAL_W-1:0];
            else
                result_reg <= sum[QW] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

endmodule

### hdl/tgi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_back
// table memory, corner fetch and the seven interpolations of a query
// ----------------------------------------------------------------------------
module tgi_back #(
    parameter int AXIS2_POINTS = tgi_pkg::AXIS_POINTS_DEF,
    parameter int AXIS3_POINTS = tgi_pkg::AXIS_POINTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tgi_pkg::tgi_cfg_t  cfg,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  tgi_pkg::tgi_work_t pop_data,
    tgi_result_if.source       result
);
    import tgi_pkg::*;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_READ  = 3'd1;
    localparam logic [2:0] B_START = 3'd2;
    localparam logic [2:0] B_WAIT  = 3'd3;
    localparam logic [2:0] B_OUT   = 3'd4;

    localparam int NUM_CORNERS = 8;
    localparam int LAST_OP     = 6;
    localparam logic [ADDR_W-1:0] OFF1 = ADDR_W'(AXIS2_POINTS * AXIS3_POINTS);
    localparam logic [ADDR_W-1:0] OFF2 = ADDR_W'(AXIS3_POINTS);

    logic [VAL_W-1:0]   mem [STORE_DEPTH];
    logic [VAL_W-1:0]   rd_data_reg;

    logic [2:0]         state_reg;
    logic [3:0]         k_reg;
    logic [3:0]         cnt_reg;
    logic [2:0]         op_reg;
    tgi_work_t          work_reg;
    logic [VAL_W-1:0]   sh_reg [NUM_CORNERS];
    logic               res_valid_reg;
    logic [VAL_W-1:0]   res_value_reg;
    logic               res_oor_reg;

    logic               out_free;
    logic               res_set;
    logic               mem_we;
    logic [ADDR_W-1:0]  rd_addr;
    logic [1:0]         axis;
    logic               lerp_start;
    logic               lerp_done;
    logic signed [VAL_W-1:0] lerp_res;

    assign out_free = !res_valid_reg || result.ready;
    assign mem_we   = (state_reg == B_IDLE) && pop_valid && pop_data.is_load;

    // a new result beat: an out-of-range query straight from the queue, or a finished one
    assign res_set  = ((state_reg == B_IDLE) && pop_valid && !pop_data.is_load
                       && pop_data.oor && out_free)
                    || ((state_reg == B_OUT) && out_free);

    always_comb
    begin
        pop_ready = 1'b0;
        if (state_reg == B_IDLE && pop_valid)
            pop_ready = pop_data.is_load || !pop_data.oor || out_free;
    end

    // corner {b1,b2,b3} of the cell, axis three the fastest
    assign rd_addr = work_reg.addr + (k_reg[2] ? OFF1 : '0) + (k_reg[1] ? OFF2 : '0)
                   + ADDR_W'(k_reg[0]);

    // four lerps along axis three, two along axis two, one along axis one
    always_comb
    begin
        if (op_reg < 3'd4)
            axis = 2'd2;
        else if (op_reg < 3'd6)
            axis = 2'd1;
        else
            axis = 2'd0;
    end

    assign lerp_start = (state_reg == B_START);

    tgi_lerp u_lerp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lerp_start),
        .v0     (sh_reg[0]),
        .v1     (sh_reg[1]),
        .r      (work_reg.rem[axis]),
        .s      (eff_step(cfg.step[axis])),
        .done   (lerp_done),
        .result (lerp_res)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[pop_data.addr] <= pop_data.value;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            k_reg         <= '0;
            cnt_reg       <= '0;
            op_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_set)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop_valid && !pop_data.is_load && !pop_data.oor)
                    begin
                        k_reg     <= '0;
                        state_reg <= B_READ;
                    end
                end
                B_READ:
                begin
                    k_reg <= k_reg + 4'd1;
                    if (k_reg == 4'(NUM_CORNERS))
                    begin
                        cnt_reg   <= 4'(NUM_CORNERS);
                        op_reg    <= '0;
                        state_reg <= B_START;
                    end
                end
                B_START:
                begin
                    cnt_reg   <= cnt_reg - 4'd2;
                    state_reg <= B_WAIT;
                end
                B_WAIT:
                begin
                    if (lerp_done)
                    begin
                        if (op_reg == 3'(LAST_OP))
                            state_reg <= B_OUT;
                        else
                        begin
                            cnt_reg   <= cnt_reg + 4'd1;
                            op_reg    <= op_reg + 3'd1;
                            state_reg <= B_START;
                        end
                    end
                end
                B_OUT:
                begin
                    if (out_free)
                        state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && pop_valid && !pop_data.is_load)
        begin
            work_reg <= pop_data;
            if (pop_data.oor && out_free)
            begin
                res_value_reg <= '0;
                res_oor_reg   <= 1'b1;
            end
        end
        // read data is registered and arrives in the cycle after its address
        if (state_reg == B_READ && k_reg != 4'd0)
            sh_reg[3'(k_reg - 4'd1)] <= rd_data_reg;
        if (state_reg == B_START)
        begin
            for (int i = 0; i < NUM_CORNERS - 2; i++)
                sh_reg[i] <= sh_reg[i + 2];
        end
        if (state_reg == B_WAIT && lerp_done)
            sh_reg[cnt_reg[2:0]] <= lerp_res;
        if (state_reg == B_OUT && out_free)
        begin
            res_value_reg <= sh_reg[0];
            res_oor_reg   <= 1'b0;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.interp_value = res_value_reg;
    assign result.out_of_range = res_oor_reg;

endmodule

### hdl/trilinear_grid_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilinear_grid_interpolator_core
// trilinear interpolation over a uniform grid table of signed q16.16 values
// ----------------------------------------------------------------------------
//  channel   dir   beat payload
//  item      in    action, entry_addr, entry_value, coord1..coord3
//  result    out   interp_value, out_of_range (one per query, none per load)
//  apb       in    axis origins and steps, register i at byte 4*i
//
//  a load skips the front's divide and is written to the table when the back takes it
//  a query makes 8 corner reads from the table, then 7 interpolations on one
//  shared unit whose bit-serial divide sets the pace
//  the front classifies the next item while the back works; a 2-deep queue parts them
//  rst_n clears control state and restores origins 0 and steps 1.0; the table is not cleared
// ----------------------------------------------------------------------------
module trilinear_grid_interpolator_core #(
    parameter int AXIS1_POINTS = tgi_pkg::AXIS_POINTS_DEF,
    parameter int AXIS2_POINTS = tgi_pkg::AXIS_POINTS_DEF,
    parameter int AXIS3_POINTS = tgi_pkg::AXIS_POINTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tgi_item_if.sink                           item,
    tgi_result_if.source                       result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tgi_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tgi_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tgi_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import tgi_pkg::*;

    tgi_cfg_t   cfg_reg;
    logic [2:0] reg_sel;
    logic       cfg_we;

    logic       push_valid;
    logic       push_ready;
    tgi_work_t  push_data;
    logic       pop_valid;
    logic       pop_ready;
    tgi_work_t  pop_data;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                cfg_reg.origin[a] <= '0;
                cfg_reg.step[a]   <= STEP_RESET;
            end
        end
        else if (cfg_we)
        begin
            unique case (reg_sel)
                REG_AXIS1_ORIGIN: cfg_reg.origin[0] <= pwdata;
                REG_AXIS2_ORIGIN: cfg_reg.origin[1] <= pwdata;
                REG_AXIS3_ORIGIN: cfg_reg.origin[2] <= pwdata;
                REG_AXIS1_STEP:   cfg_reg.step[0]   <= pwdata[STEP_W-1:0];
                REG_AXIS2_STEP:   cfg_reg.step[1]   <= pwdata[STEP_W-1:0];
                REG_AXIS3_STEP:   cfg_reg.step[2]   <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_AXIS1_ORIGIN: prdata = cfg_reg.origin[0];
            REG_AXIS2_ORIGIN: prdata = cfg_reg.origin[1];
            REG_AXIS3_ORIGIN: prdata = cfg_reg.origin[2];
            REG_AXIS1_STEP:   prdata = {1'b0, cfg_reg.step[0]};
            REG_AXIS2_STEP:   prdata = {1'b0, cfg_reg.step[1]};
            REG_AXIS3_STEP:   prdata = {1'b0, cfg_reg.step[2]};
            default:          prdata = '0;
        endcase
    end

    tgi_front #(
        .AXIS1_POINTS (AXIS1_POINTS),
        .AXIS2_POINTS (AXIS2_POINTS),
        .AXIS3_POINTS (AXIS3_POINTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tgi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tgi_back #(
        .AXIS2_POINTS (AXIS2_POINTS),
        .AXIS3_POINTS (AXIS3_POINTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

`ifndef SYNTHESIS
    // an out-of-range beat always carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.out_of_range) |-> (result.interp_value == '0))
        else $error("out-of-range result with nonzero value");

    // the front takes one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("front ready right after accepting a beat");

    // the front holds its work while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_ready) |=> push_valid)
        else $error("front dropped work while the queue was full");
`endif

endmodule

### tb/tgi_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_scoreboard
// watches the item, result and apb channels, keeps a private copy of the
// axis registers and the grid table, predicts each query and compares
// ----------------------------------------------------------------------------
module tgi_scoreboard (
    input  logic                           clk,
    input  logic                           rst_n,
    tgi_item_if                            item,
    tgi_result_if                          result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [tgi_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tgi_pkg::APB_DATA_W-1:0] pwdata,
    output int                             fail_count,
    output int                             pending,
    output int                             results_seen,
    output int                             oor_seen
);
    import tgi_pkg::*;

    localparam longint N1 = 16;
    localparam longint N2 = 16;
    localparam longint N3 = 16;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic                    oor;
    } interp_result_t;

    typedef struct {
        bit     ok;
        longint idx;
        longint rem;
        longint s;
    } cell_pos_t;

    interp_result_t          expected_results[$];
    logic [VAL_W-1:0]        grid_mem [STORE_DEPTH];
    logic signed [VAL_W-1:0] axis_origin [NUM_AXES];
    logic [STEP_W-1:0]       axis_step [NUM_AXES];

    function automatic cell_pos_t find_cell(logic signed [VAL_W-1:0] coord,
                                            logic signed [VAL_W-1:0] origin,
                                            logic [STEP_W-1:0] stepv, longint points);
        cell_pos_t c;
        longint d;
        c.s = (stepv == '0) ? 64'sd1 : longint'(stepv);
        d = longint'(coord) - longint'(origin);
        c.ok = (d >= 0) && (d <= (points - 1) * c.s);
        c.idx = 0;
        c.rem = 0;
        if (c.ok)
        begin
            c.idx = d / c.s;
            if (c.idx >= points - 1)
                c.idx = points - 2;
            c.rem = d - c.idx * c.s;
        end
        return c;
    endfunction

    // v0 + (v1-v0)*r/s rounded half up, saturated to 32 bits
    function automatic longint blend(longint v0, longint v1, longint r, longint s);
        longint p, q, rm;
        p = (v1 - v0) * r;
        q = p / s;
        rm = p % s;
        if (rm < 0)
        begin
            q = q - 1;
            rm = rm + s;
        end
        if (2 * rm >= s)
            q = q + 1;
        q = q + v0;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q;
    endfunction

    function automatic longint grid_at(longint i1, longint i2, longint i3);
        longint a;
        a = (i1 * N2 * N3 + i2 * N3 + i3) % STORE_DEPTH;
        return longint'($signed(grid_mem[a]));
    endfunction

    function automatic interp_result_t interpolate(logic signed [VAL_W-1:0] c1,
                                                   logic signed [VAL_W-1:0] c2,
                                                   logic signed [VAL_W-1:0] c3);
        interp_result_t res;
        cell_pos_t a1, a2, a3;
        longint c00, c10, c01, c11, e0, e1;
        a1 = find_cell(c1, axis_origin[0], axis_step[0], N1);
        a2 = find_cell(c2, axis_origin[1], axis_step[1], N2);
        a3 = find_cell(c3, axis_origin[2], axis_step[2], N3);
        if (!a1.ok || !a2.ok || !a3.ok)
        begin
            res.value = '0;
            res.oor = 1'b1;
            return res;
        end
        c00 = blend(grid_at(a1.idx, a2.idx, a3.idx), grid_at(a1.idx, a2.idx, a3.idx + 1),
                    a3.rem, a3.s);
        c10 = blend(grid_at(a1.idx + 1, a2.idx, a3.idx),
                    grid_at(a1.idx + 1, a2.idx, a3.idx + 1), a3.rem, a3.s);
        c01 = blend(grid_at(a1.idx, a2.idx + 1, a3.idx),
                    grid_at(a1.idx, a2.idx + 1, a3.idx + 1), a3.rem, a3.s);
        c11 = blend(grid_at(a1.idx + 1, a2.idx + 1, a3.idx),
                    grid_at(a1.idx + 1, a2.idx + 1, a3.idx + 1), a3.rem, a3.s);
        e0 = blend(c00, c01, a2.rem, a2.s);
        e1 = blend(c10, c11, a2.rem, a2.s);
        res.value = VAL_W'(blend(e0, e1, a1.rem, a1.s));
        res.oor = 1'b0;
        return res;
    endfunction

    initial
    begin
        fail_count = 0;
        pending = 0;
        results_seen = 0;
        oor_seen = 0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            axis_origin[i] = '0;
            axis_step[i] = STEP_RESET;
        end
    end

    always @(posedge clk)
    begin
        interp_result_t exp_r;
        logic [2:0] reg_idx;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                reg_idx = paddr[4:2];
                case (reg_idx)
                    REG_AXIS1_ORIGIN: axis_origin[0] = pwdata;
                    REG_AXIS2_ORIGIN: axis_origin[1] = pwdata;
                    REG_AXIS3_ORIGIN: axis_origin[2] = pwdata;
                    REG_AXIS1_STEP:   axis_step[0] = pwdata[STEP_W-1:0];
                    REG_AXIS2_STEP:   axis_step[1] = pwdata[STEP_W-1:0];
                    REG_AXIS3_STEP:   axis_step[2] = pwdata[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
            begin
                if (item.action == ACTION_LOAD)
                    grid_mem[item.entry_addr] = item.entry_value;
                else
                    expected_results.push_back(interpolate(item.coord1, item.coord2,
                                                           item.coord3));
            end
            if (result.valid && result.ready)
            begin
                results_seen++;
                if (result.out_of_range)
                    oor_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result.interp_value !== exp_r.value)
                    begin
                        $error("interp_value expected %0d actual %0d", exp_r.value,
                               result.interp_value);
                        fail_count++;
                    end
                    if (result.out_of_range !== exp_r.oor)
                    begin
                        $error("out_of_range expected %0b actual %0b", exp_r.oor,
                               result.out_of_range);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// loads the first and last cells of each axis, then runs directed and random
// load/query traffic over several axis settings with random stalls on both channels
// ----------------------------------------------------------------------------
module testbench;
    import tgi_pkg::*;

    localparam int     CYCLE_LIMIT = 3000000;
    localparam int     DRAIN_WAIT  = 400;
    localparam longint SPAN_CELLS  = 15;
    localparam int     PLANE       = AXIS_POINTS_DEF * AXIS_POINTS_DEF;
    localparam int     EDGE_CELLS [4] = '{0, 1, 14, 15};

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count, pending, results_seen, oor_seen;
    int cycles, loads_sent, queries_sent;
    int stall_hold;
    bit no_idle;

    logic signed [VAL_W-1:0] cur_origin [NUM_AXES];
    logic [STEP_W-1:0]       cur_step [NUM_AXES];

    tgi_item_if   item_ch();
    tgi_result_if res_ch();

    trilinear_grid_interpolator_core uut (
        .clk(clk), .rst_n(rst_n), .item(item_ch), .result(res_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tgi_scoreboard scoreboard (
        .clk(clk), .rst_n(rst_n), .item(item_ch), .result(res_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count),
        .pending(pending), .results_seen(results_seen), .oor_seen(oor_seen)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int gap_len();
        int pick;
        if (no_idle)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_hold <= 0;
        end
        else if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            res_ch.ready <= no_idle || ($urandom_range(0, 2) != 0);
            stall_hold <= gap_len();
        end
    end

    // one beat; valid only drops when a gap follows
    task automatic push(logic act, logic [ADDR_W-1:0] addr, logic signed [VAL_W-1:0] val,
                        logic signed [VAL_W-1:0] c1, logic signed [VAL_W-1:0] c2,
                        logic signed [VAL_W-1:0] c3);
        int gap;
        item_ch.valid <= 1'b1;
        item_ch.action <= act;
        item_ch.entry_addr <= addr;
        item_ch.entry_value <= val;
        item_ch.coord1 <= c1;
        item_ch.coord2 <= c2;
        item_ch.coord3 <= c3;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (act == ACTION_LOAD)
            loads_sent++;
        else
            queries_sent++;
        gap = gap_len();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load(logic [ADDR_W-1:0] addr, logic signed [VAL_W-1:0] val);
        push(ACTION_LOAD, addr, val, $urandom, $urandom, $urandom);
    endtask

    task automatic query(logic signed [VAL_W-1:0] c1, logic signed [VAL_W-1:0] c2,
                         logic signed [VAL_W-1:0] c3);
        push(ACTION_QUERY, ADDR_W'($urandom), $urandom, c1, c2, c3);
    endtask

    // setup and access phases, then idle with psel low
    task automatic apb_write(logic [2:0] reg_idx, logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic quiesce();
        item_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_axes(logic signed [VAL_W-1:0] o1, logic signed [VAL_W-1:0] o2,
                            logic signed [VAL_W-1:0] o3, logic [STEP_W-1:0] s1,
                            logic [STEP_W-1:0] s2, logic [STEP_W-1:0] s3);
        quiesce();
        apb_write(REG_AXIS1_ORIGIN, o1);
        apb_write(REG_AXIS2_ORIGIN, o2);
        apb_write(REG_AXIS3_ORIGIN, o3);
        apb_write(REG_AXIS1_STEP, {1'b0, s1});
        apb_write(REG_AXIS2_STEP, {1'b0, s2});
        apb_write(REG_AXIS3_STEP, {1'b0, s3});
        cur_origin[0] = o1;
        cur_origin[1] = o2;
        cur_origin[2] = o3;
        cur_step[0] = s1;
        cur_step[1] = s2;
        cur_step[2] = s3;
    endtask

    function automatic logic signed [VAL_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 32'sh7fffffff;
        if (pick == 1)
            return 32'sh80000000;
        if (pick < 8)
            return $signed(32'($urandom_range(0, 32'h000fffff))) - 32'sh00080000;
        return $urandom;
    endfunction

    // first or last cell of the axis, grid points, the end point, near misses and random coordinates
    function automatic logic signed [VAL_W-1:0] rand_coord(int ax);
        longint s, span, d, c;
        int pick;
        s = (cur_step[ax] == '0) ? 64'sd1 : longint'(cur_step[ax]);
        span = SPAN_CELLS * s;
        pick = $urandom_range(0, 99);
        if (pick < 68)
        begin
            d = longint'({$urandom, $urandom} % s);
            if ($urandom_range(0, 1) != 0)
                d = d + (SPAN_CELLS - 1) * s;
        end
        else if (pick < 78)
            d = ($urandom_range(0, 1) != 0) ? (SPAN_CELLS - 1) * s : 64'sd0;
        else if (pick < 84)
            d = span;
        else if (pick < 88)
            d = -1;
        else if (pick < 92)
            d = span + 1;
        else
            d = longint'($signed($urandom)) - longint'(cur_origin[ax]);
        c = longint'(cur_origin[ax]) + d;
        if (c > 64'sd2147483647 || c < -64'sd2147483648)
        begin
            c = longint'($signed($urandom));
            d = c - longint'(cur_origin[ax]);
        end
        // only the first and the last cell of each axis are sure to have loaded corners
        if (d >= 0 && d <= span && d / s != 0 && d / s < SPAN_CELLS - 1)
            c = longint'(cur_origin[ax]);
        return VAL_W'(c);
    endfunction

    task automatic random_traffic(int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 30)
                load(ADDR_W'($urandom), rand_value());
            else
                query(rand_coord(0), rand_coord(1), rand_coord(2));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_ch.valid = 1'b0;
        item_ch.action = ACTION_QUERY;
        item_ch.entry_addr = '0;
        item_ch.entry_value = '0;
        item_ch.coord1 = '0;
        item_ch.coord2 = '0;
        item_ch.coord3 = '0;
        cycles = 0;
        loads_sent = 0;
        queries_sent = 0;
        no_idle = 1'b0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            cur_origin[i] = '0;
            cur_step[i] = STEP_RESET;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners of the first and last cell on every axis, written before any query
        no_idle = 1'b1;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                for (int k = 0; k < 4; k++)
                    load(ADDR_W'(EDGE_CELLS[i] * PLANE + EDGE_CELLS[j] * AXIS_POINTS_DEF
                                 + EDGE_CELLS[k]), rand_value());
        no_idle = 1'b0;

        // directed, reset axis settings (origin 0, step 1.0)
        load(ADDR_W'(0), 32'sh80000000);
        load(ADDR_W'(STORE_DEPTH - 1), 32'sh7fffffff);
        load(ADDR_W'(1), 32'sh7fffffff);
        query(0, 0, 0);
        query(32'sh000f0000, 32'sh000f0000, 32'sh000f0000);
        query(32'sh0000ffff, 32'sh00008000, 32'sh00000001);
        query(32'sh000e8000, 32'sh00004000, 32'sh000e8000);
        query(32'sh000f0001, 0, 0);
        query(0, -1, 0);
        query(0, 0, 32'sh80000000);
        query(32'sh7fffffff, 0, 0);
        query(32'sh000e8000, 32'sh000f0000, 32'sh0000c000);
        query(0, 0, 32'sh00008000);

        set_axes(32'sh80000000, 32'sh80000000, 32'sh80000000,
                 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        query(32'sh80000000, 32'sh80000000, 32'sh80000000);
        query(32'shfffffffe, 32'shfffffffe, 32'shfffffffe);
        random_traffic(120);

        set_axes(32'sh7fffffff, -32'sd5, 0, 31'd1, 31'd0, 31'd1);
        query(32'sh7fffffff, -32'sd5, 0);
        random_traffic(120);

        no_idle = 1'b1;
        set_axes(-32'sh00080000, 32'sh00010000, 32'sh00003000,
                 31'h00008000, 31'h00010000, 31'h00001800);
        random_traffic(120);
        no_idle = 1'b0;

        for (int ph = 0; ph < 3; ph++)
        begin
            set_axes($urandom, $signed(32'($urandom_range(0, 32'h00ffffff))) - 32'sh00800000,
                     $urandom, STEP_W'($urandom_range(1, 32'h000fffff)),
                     STEP_W'($urandom_range(1, 32'h7fffffff)),
                     STEP_W'($urandom_range(1, 200)));
            random_traffic(140);
        end

        quiesce();
        $display("loads %0d, queries %0d over seven axis settings", loads_sent, queries_sent);
        $display("results checked %0d, out of range %0d", results_seen, oor_seen);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
